[design/dce_pkg.sv]
// shared types, register offsets and codes for the dma copy engine
package dce_pkg;

  localparam int LOG_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [15:0] REG_BASE   = 16'h3000;
  localparam logic [15:0] OFF_CTRL   = 16'h0000;
  localparam logic [15:0] OFF_STATUS = 16'h0004;
  localparam logic [15:0] OFF_SRC    = 16'h0008;
  localparam logic [15:0] OFF_DST    = 16'h000c;
  localparam logic [15:0] OFF_COUNT  = 16'h0014;
  localparam logic [15:0] OFF_TRIG   = 16'h001c;
  localparam logic [15:0] OFF_UNIT   = 16'h0020;
  localparam logic [15:0] OFF_MASK   = 16'h0024;
  localparam logic [15:0] OFF_FREEZE = 16'h0028;
  localparam logic [15:0] OFF_KEY    = 16'h0030;
  localparam logic [15:0] OFF_COPIES = 16'h0038;
  localparam logic [15:0] HIST_LO    = 16'h0400;
  localparam logic [15:0] HIST_HI    = 16'h07ff;

  localparam logic [1:0] KIND_BUS = 2'd0;
  localparam logic [1:0] KIND_RD  = 2'd1;
  localparam logic [1:0] KIND_WR  = 2'd2;

  localparam logic [31:0] STATUS_IDLE    = 32'd0;
  localparam logic [31:0] STATUS_DONE    = 32'd1;
  localparam logic [31:0] STATUS_RUNNING = 32'd2;
  localparam logic [31:0] STATUS_ERROR   = 32'd3;
  localparam logic [31:0] UNIT_RESET     = 32'd4;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_RETURN = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    REG_CTRL, REG_STATUS, REG_SRC, REG_DST, REG_COUNT, REG_TRIG, REG_UNIT,
    REG_MASK, REG_FREEZE, REG_KEY, REG_COPIES, REG_HIST, REG_NONE
  } reg_sel_t;

  typedef struct packed {
    action_t     op;
    reg_sel_t    sel;
    logic [7:0]  hist_idx;
    logic [31:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_EXEC, B_MUL, B_REQ, B_LOG2, B_NEXT
  } back_state_t;

endpackage

[design/dce_front.sv]
// front end: accepts a word and decodes it into a command for the queue
module dce_front (
  input  logic           start,
  input  logic           busy,
  input  logic [1:0]     action,
  input  logic [15:0]    bus_address,
  input  logic [31:0]    bus_data,
  output logic           push,
  output dce_pkg::cmd_t  cmd
);
  import dce_pkg::*;

  logic [15:0] off;
  logic        in_window;

  assign off       = bus_address - REG_BASE;
  assign in_window = (bus_address >= REG_BASE);

  always_comb begin
    cmd.op       = action_t'(action);
    cmd.data     = bus_data;
    cmd.hist_idx = off[9:2];
    cmd.sel      = REG_NONE;
    if (in_window) begin
      case (off)
        OFF_CTRL:   cmd.sel = REG_CTRL;
        OFF_STATUS: cmd.sel = REG_STATUS;
        OFF_SRC:    cmd.sel = REG_SRC;
        OFF_DST:    cmd.sel = REG_DST;
        OFF_COUNT:  cmd.sel = REG_COUNT;
        OFF_TRIG:   cmd.sel = REG_TRIG;
        OFF_UNIT:   cmd.sel = REG_UNIT;
        OFF_MASK:   cmd.sel = REG_MASK;
        OFF_FREEZE: cmd.sel = REG_FREEZE;
        OFF_KEY:    cmd.sel = REG_KEY;
        OFF_COPIES: cmd.sel = REG_COPIES;
        default: begin
          if (off inside {[HIST_LO:HIST_HI]}) cmd.sel = REG_HIST;
        end
      endcase
    end
  end

  // action 3 is taken and dropped here
  assign push = start && !busy && (action_t'(action) != ACT_NONE);

endmodule

[design/dce_queue.sv]
// short command queue between the front end and the back end
module dce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dce_pkg::cmd_t  cmd_in,
  input  logic           pop,
  output dce_pkg::cmd_t  head,
  output logic           empty,
  output logic           full
);
  import dce_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == CW'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

endmodule

[design/dce_back.sv]
// back end: register file, transfer sequencer and history ring
module dce_back #(
  parameter int LOG_DEPTH = dce_pkg::LOG_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  dce_pkg::cmd_t  head,
  input  logic           empty,
  output logic           pop,
  output logic           clearing,
  output logic           strobe,
  output logic [1:0]     kind,
  output logic [31:0]    out_address,
  output logic [31:0]    out_data,
  output logic           last
);
  import dce_pkg::*;

  localparam int AW = $clog2(LOG_DEPTH);

  back_state_t state;
  back_state_t state_next;

  logic        dir_rev;
  logic        frozen;
  logic        running;
  logic [31:0] status_word;
  logic [31:0] source_base;
  logic [31:0] dest_base;
  logic [31:0] remaining_count;
  logic [31:0] unit_bytes;
  logic [31:0] addr_mask;
  logic [31:0] data_key;
  logic [31:0] copies_done;
  logic [31:0] read_pointer;
  logic [31:0] write_pointer;
  logic [AW-1:0] log_slot;
  logic [AW-1:0] clr_idx;

  cmd_t        cur;
  logic [31:0] prod;
  logic [31:0] wa_q;
  logic [31:0] w_q;
  logic [31:0] rd_q;
  logic [31:0] log_mem [LOG_DEPTH];

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic [AW-1:0] mem_ra;
  logic [31:0]   head_idx;
  logic [31:0]   cur_idx;

  logic          emit;
  logic [1:0]    e_kind;
  logic [31:0]   e_addr;
  logic [31:0]   e_data;
  logic          e_last;

  logic          is_write;
  logic          is_return;
  logic          locked;
  logic          want_start;
  logic          count_zero;
  logic          last_copy;
  logic          do_finish;
  logic          hist_ok;
  logic [31:0]   resp;
  logic [31:0]   rp_start;
  logic [31:0]   wa;
  logic [31:0]   w;
  logic [AW-1:0] slot_inc;

  function automatic logic [31:0] apply_mask(input logic [31:0] a, input logic [31:0] m);
    return (m != '0) ? (a & m) : a;
  endfunction

  function automatic logic [31:0] unit_keep(input logic [31:0] ub);
    logic [31:0] k;
    case (ub)
      32'd0:   k = 32'h0000_0000;
      32'd1:   k = 32'h0000_00ff;
      32'd2:   k = 32'h0000_ffff;
      32'd3:   k = 32'h00ff_ffff;
      default: k = 32'hffff_ffff;
    endcase
    return k;
  endfunction

  assign clearing   = (state == B_CLEAR);
  assign is_write   = (cur.op == ACT_WRITE);
  assign is_return  = (cur.op == ACT_RETURN);
  assign locked     = frozen || running;
  assign count_zero = (remaining_count == '0);
  assign last_copy  = (remaining_count == 32'd1);
  assign slot_inc   = (log_slot == AW'(LOG_DEPTH - 1)) ? '0 : log_slot + 1'b1;
  assign head_idx   = {24'b0, head.hist_idx};
  assign cur_idx    = {24'b0, cur.hist_idx};
  assign mem_ra     = head_idx[AW-1:0];
  assign hist_ok    = (cur_idx < 32'(LOG_DEPTH));
  assign wa         = apply_mask(write_pointer, addr_mask);
  assign w          = (cur.data ^ data_key) & unit_keep(unit_bytes);
  assign rp_start   = dir_rev ? source_base + prod : source_base;

  always_comb begin
    want_start = 1'b0;
    if (is_write && !running) begin
      case (cur.sel)
        REG_STATUS: want_start = !(cur.data inside {STATUS_IDLE, STATUS_DONE, STATUS_ERROR});
        REG_TRIG:   want_start = (cur.data != '0);
        default:    want_start = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (cur.sel)
      REG_COPIES: resp = copies_done;
      REG_HIST:   resp = hist_ok ? rd_q : '0;
      default: begin
        if (is_write) begin
          resp = '0;
        end else begin
          case (cur.sel)
            REG_STATUS: resp = status_word;
            REG_SRC:    resp = source_base;
            REG_DST:    resp = dest_base;
            REG_COUNT:  resp = remaining_count;
            REG_UNIT:   resp = unit_bytes;
            REG_MASK:   resp = addr_mask;
            REG_KEY:    resp = data_key;
            default:    resp = '0;
          endcase
        end
      end
    endcase
  end

  assign do_finish = ((state == B_EXEC) && want_start && count_zero) ||
                     ((state == B_LOG2) && last_copy);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: if (clr_idx == AW'(LOG_DEPTH - 1)) state_next = B_IDLE;
      B_IDLE:  if (!empty) state_next = B_EXEC;
      B_EXEC: begin
        if (is_return) begin
          state_next = running ? B_LOG2 : B_IDLE;
        end else begin
          state_next = (want_start && !count_zero) ? B_MUL : B_IDLE;
        end
      end
      B_MUL:   state_next = B_REQ;
      B_REQ:   state_next = B_IDLE;
      B_LOG2:  state_next = last_copy ? B_IDLE : B_NEXT;
      B_NEXT:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop    = 1'b0;
    mem_we = 1'b0;
    mem_wa = log_slot;
    mem_wd = '0;
    emit   = 1'b0;
    e_kind = KIND_BUS;
    e_addr = '0;
    e_data = '0;
    e_last = 1'b1;
    case (state)
      B_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
      end
      B_IDLE: pop = !empty;
      B_EXEC: begin
        if (is_return) begin
          mem_we = running;
          mem_wd = wa;
        end else begin
          emit   = 1'b1;
          e_data = resp;
          e_last = !(want_start && !count_zero);
        end
      end
      B_REQ: begin
        emit   = 1'b1;
        e_kind = KIND_RD;
        e_addr = apply_mask(rp_start, addr_mask);
      end
      B_LOG2: begin
        mem_we = 1'b1;
        mem_wd = w_q;
        emit   = 1'b1;
        e_kind = KIND_WR;
        e_addr = wa_q;
        e_data = w_q;
        e_last = last_copy;
      end
      B_NEXT: begin
        emit   = 1'b1;
        e_kind = KIND_RD;
        e_addr = apply_mask(read_pointer, addr_mask);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= B_CLEAR;
      clr_idx         <= '0;
      dir_rev         <= 1'b0;
      frozen          <= 1'b0;
      running         <= 1'b0;
      status_word     <= STATUS_IDLE;
      source_base     <= '0;
      dest_base       <= '0;
      remaining_count <= '0;
      unit_bytes      <= UNIT_RESET;
      addr_mask       <= '0;
      data_key        <= '0;
      copies_done     <= '0;
      read_pointer    <= '0;
      write_pointer   <= '0;
      log_slot        <= '0;
      strobe          <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (state == B_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (((state == B_EXEC) && is_return && running) || (state == B_LOG2)) begin
        log_slot <= slot_inc;
      end
      if (do_finish) begin
        dir_rev         <= 1'b0;
        frozen          <= 1'b0;
        running         <= 1'b0;
        status_word     <= STATUS_ERROR;
        source_base     <= '0;
        dest_base       <= '0;
        remaining_count <= '0;
        unit_bytes      <= '0;
        addr_mask       <= '0;
        data_key        <= '0;
        copies_done     <= '0;
        read_pointer    <= '0;
        write_pointer   <= '0;
      end else begin
        case (state)
          B_EXEC: begin
            if (is_write) begin
              case (cur.sel)
                REG_CTRL:   if (!locked) dir_rev <= cur.data[0];
                REG_SRC:    if (!locked) source_base <= cur.data;
                REG_DST:    if (!locked) dest_base <= cur.data;
                REG_COUNT:  if (!locked) remaining_count <= cur.data;
                REG_UNIT:   if (!locked) unit_bytes <= cur.data;
                REG_MASK:   if (!locked) addr_mask <= cur.data;
                REG_KEY:    if (!locked) data_key <= cur.data;
                REG_FREEZE: if (!running) frozen <= 1'b1;
                REG_STATUS: if (!running) status_word <= cur.data;
                REG_TRIG:   if (!running && cur.data != '0) status_word <= STATUS_RUNNING;
                default: ;
              endcase
            end
          end
          B_REQ: begin
            read_pointer  <= rp_start;
            write_pointer <= dest_base;
            running       <= 1'b1;
          end
          B_LOG2: begin
            read_pointer    <= dir_rev ? read_pointer - unit_bytes : read_pointer + unit_bytes;
            write_pointer   <= write_pointer + unit_bytes;
            remaining_count <= remaining_count - 32'd1;
            copies_done     <= copies_done + 32'd1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    prod        <= unit_bytes * (remaining_count - 32'd1);
    wa_q        <= wa;
    w_q         <= w;
    kind        <= e_kind;
    out_address <= e_addr;
    out_data    <= e_data;
    last        <= e_last;
  end

  // history ring
  always_ff @(posedge clk) begin
    if (mem_we) log_mem[mem_wa] <= mem_wd;
    rd_q <= log_mem[mem_ra];
  end

endmodule

[design/dma_copy_engine_registers_top.sv]
// top level of the single-channel dma copy engine
// bus read or write: the word passes the queue, the command register and the output registers;
//   a start adds a multiply state, then an add and issue state, before the read request
// memory data return: write result from the LOG2 state, next read request from NEXT;
//   the last word skips NEXT; EXEC and LOG2 each write the history ring through one port
// reset sets the control registers to reset values, then a pass zeroes every ring slot with busy high
// results cannot be stalled; a two-entry command queue absorbs new words meanwhile
module dma_copy_engine_registers_top #(
  parameter int LOG_DEPTH = dce_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] bus_address,
  input  logic [31:0] bus_data,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [31:0] out_address,
  output logic [31:0] out_data,
  output logic        last
);
  import dce_pkg::*;

  cmd_t cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;
  logic clearing;

  assign busy = full || clearing;

  dce_front u_front (
    .start       (start),
    .busy        (busy),
    .action      (action),
    .bus_address (bus_address),
    .bus_data    (bus_data),
    .push        (push),
    .cmd         (cmd)
  );

  dce_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  dce_back #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .clearing    (clearing),
    .strobe      (strobe),
    .kind        (kind),
    .out_address (out_address),
    .out_data    (out_data),
    .last        (last)
  );

endmodule

[design/dce_checker.sv]
// port-level checks for the dma copy engine, bound to the top level
module dce_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        strobe,
  input logic [1:0]  kind,
  input logic [31:0] out_address,
  input logic [31:0] out_data,
  input logic        last
);
  import dce_pkg::*;

  a_bus_resp_addr: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_BUS |-> out_address == '0)
    else $error("bus response with nonzero address");

  a_rd_req_data: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_RD |-> out_data == '0 && last)
    else $error("read request with data or not last");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> kind == KIND_BUS || kind == KIND_RD || kind == KIND_WR)
    else $error("illegal result kind");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("word accepted during ring clear");

  a_write_then_more: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_WR && !last |=> strobe && kind == KIND_RD)
    else $error("write not followed by read request");

endmodule

bind dma_copy_engine_registers_top dce_checker u_dce_checker (.*);
